FILE: rtl/qws_pkg.sv
// Shared types and constants of the quote-aware word splitter.
// Holds the payload structs, the parser state enums and the byte codes.
// No dependencies.
package qws_pkg;

    // Width of a word counter; it holds WORD_LIMIT itself.
    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] WORD_LIMIT = 6'd32;

    // Configuration register indexes.
    localparam logic CFG_SEPARATOR_SET = 1'b0;
    localparam logic CFG_MAX_WORDS     = 1'b1;

    // Byte codes.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_WORD,
        PH_BETWEEN,
        PH_QPEND
    } phase_t;

    typedef enum logic [1:0] {
        Q_NONE,
        Q_SINGLE,
        Q_DOUBLE
    } quote_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic             word_byte;
        logic [7:0]       byte_out;
        logic [4:0]       word_index;
        logic             word_closed;
        logic             done_res;
        logic [CNT_W-1:0] word_count;
        logic             limit_hit;
    } result_t;

    // A byte after classification by the front end.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
        logic       is_sep;
        quote_t     quote;
        logic       is_escape;
    } cls_t;

    // Configuration as seen by the front and back ends.
    typedef struct packed {
        logic             separator_set;
        logic [CNT_W-1:0] word_limit;
    } cfg_t;

endpackage

FILE: rtl/qws_front.sv
// Front end of the word splitter: accepts bytes, classifies them and
// holds them in a two-beat queue for the back end. Depends on qws_pkg.
module qws_front
    import qws_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  push,
    output logic  full,
    input  item_t item,
    output logic  cls_valid,
    input  logic  cls_take,
    output cls_t  cls
);

    cls_t       mem_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    cls_t       cls_new;
    logic       wr;
    logic       rd;

    always_comb
    begin
        cls_new.byte_value = item.byte_value;
        cls_new.last_byte  = item.last_byte;
        cls_new.is_sep     = (item.byte_value == CH_SPACE) || (item.byte_value == CH_TAB)
                          || (item.byte_value == CH_CR) || (item.byte_value == CH_LF)
                          || (cfg.separator_set ? (item.byte_value == CH_COMMA)
                                                : (item.byte_value == CH_EQUALS));
        if (item.byte_value == CH_SQUOTE)
        begin
            cls_new.quote = Q_SINGLE;
        end
        else if (item.byte_value == CH_DQUOTE)
        begin
            cls_new.quote = Q_DOUBLE;
        end
        else
        begin
            cls_new.quote = Q_NONE;
        end
        cls_new.is_escape = (item.byte_value == CH_BSLASH);
    end

    assign full      = (count_reg == 2'd2);
    assign cls_valid = (count_reg != 2'd0);
    assign cls       = mem_reg[0];
    assign wr        = push && !full;
    assign rd        = cls_take && cls_valid;

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // A read together with a write only happens with one beat held, so the
    // new beat goes straight to the head.
    always_ff @(posedge clk)
    begin
        if (rd)
        begin
            if (wr)
            begin
                mem_reg[0] <= cls_new;
            end
            else
            begin
                mem_reg[0] <= mem_reg[1];
            end
        end
        else if (wr)
        begin
            mem_reg[count_reg[0]] <= cls_new;
        end
    end

endmodule

FILE: rtl/qws_back.sv
// Back end of the word splitter: runs the per-line parser state machine
// on classified bytes and queues results in a two-beat output queue.
// Depends on qws_pkg.
module qws_back
    import qws_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    cls_valid,
    output logic    cls_take,
    input  cls_t    cls,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    phase_t           phase_reg;
    phase_t           phase_next;
    quote_t           quote_reg;
    quote_t           quote_next;
    logic             esc_reg;
    logic             esc_next;
    logic [CNT_W-1:0] words_reg;
    logic [CNT_W-1:0] words_next;
    logic             stop_reg;
    logic             stop_next;

    result_t          res_new;
    result_t          mem_reg [2];
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             rd;
    logic             inword;
    logic [CNT_W-1:0] words_m1;

    assign cls_take = cls_valid && (count_reg != 2'd2);
    assign rd       = pop && !empty;
    assign empty    = (count_reg == 2'd0);
    assign result   = mem_reg[0];

    always_comb
    begin
        phase_next = phase_reg;
        quote_next = quote_reg;
        esc_next   = esc_reg;
        words_next = words_reg;
        stop_next  = stop_reg;
        inword     = 1'b0;
        res_new.word_byte   = 1'b0;
        res_new.word_closed = 1'b0;

        if (stop_reg)
        begin
            // Bytes after the word limit are dropped.
        end
        else if (esc_reg)
        begin
            esc_next          = 1'b0;
            res_new.word_byte = 1'b1;
        end
        else
        begin
            unique case (phase_reg) inside
                PH_LEAD, PH_BETWEEN:
                begin
                    if (!cls.is_sep)
                    begin
                        if (cls.quote != Q_NONE)
                        begin
                            quote_next = cls.quote;
                            phase_next = PH_QPEND;
                        end
                        else
                        begin
                            inword = 1'b1;
                        end
                    end
                end
                PH_WORD, PH_QPEND:
                begin
                    inword = 1'b1;
                end
                default:
                begin
                    inword = 1'b1;
                end
            endcase
        end

        // Opening a new word checks the word limit.
        if (inword && (phase_next != PH_WORD))
        begin
            if ((words_reg != '0) && (words_reg >= cfg.word_limit))
            begin
                stop_next = 1'b1;
                inword    = 1'b0;
            end
            else
            begin
                words_next = words_reg + CNT_W'(1);
                phase_next = PH_WORD;
            end
        end

        if (inword)
        begin
            if (cls.is_escape && !cls.last_byte)
            begin
                esc_next          = 1'b1;
                res_new.word_byte = 1'b1;
            end
            else if ((quote_next != Q_NONE) && (cls.quote == quote_next))
            begin
                quote_next          = Q_NONE;
                phase_next          = PH_BETWEEN;
                res_new.word_closed = 1'b1;
            end
            else if ((quote_next == Q_NONE) && cls.is_sep)
            begin
                phase_next          = PH_BETWEEN;
                res_new.word_closed = 1'b1;
            end
            else
            begin
                res_new.word_byte = 1'b1;
            end
        end

        // Line end closes an open word, or the empty first word.
        if (cls.last_byte && !stop_next)
        begin
            if (phase_next == PH_WORD)
            begin
                res_new.word_closed = 1'b1;
            end
            else if ((words_next == '0)
                     && ((phase_next == PH_LEAD) || (phase_next == PH_QPEND)))
            begin
                words_next          = {{(CNT_W-1){1'b0}}, 1'b1};
                res_new.word_closed = 1'b1;
            end
        end

        words_m1           = words_next - CNT_W'(1);
        res_new.byte_out   = cls.byte_value;
        res_new.word_index = (words_next == '0) ? 5'd0 : words_m1[4:0];
        res_new.done_res   = cls.last_byte;
        res_new.word_count = cls.last_byte ? words_next : '0;
        res_new.limit_hit  = stop_next;

        if (cls.last_byte)
        begin
            phase_next = PH_LEAD;
            quote_next = Q_NONE;
            esc_next   = 1'b0;
            words_next = '0;
            stop_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            quote_reg <= Q_NONE;
            esc_reg   <= 1'b0;
            words_reg <= '0;
            stop_reg  <= 1'b0;
        end
        else if (cls_take)
        begin
            phase_reg <= phase_next;
            quote_reg <= quote_next;
            esc_reg   <= esc_next;
            words_reg <= words_next;
            stop_reg  <= stop_next;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cls_take && !rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd && !cls_take)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // A pop together with a new result only happens with one result held,
    // so the new result goes straight to the head.
    always_ff @(posedge clk)
    begin
        if (rd)
        begin
            if (cls_take)
            begin
                mem_reg[0] <= res_new;
            end
            else
            begin
                mem_reg[0] <= mem_reg[1];
            end
        end
        else if (cls_take)
        begin
            mem_reg[count_reg[0]] <= res_new;
        end
    end

endmodule

FILE: rtl/quote_aware_word_splitter_top.sv
// Top level of the quote-aware word splitter: configuration registers and
// the front and back ends. Depends on qws_pkg, qws_front and qws_back.
//
// Usage. Text bytes enter as beats on a queue-like input: a beat is taken
// at a clock edge where push is high and full is low. Results leave the
// same way: while empty is low the oldest result sits on the result port,
// and it is taken at an edge where pop is high. Each byte beat yields
// exactly one result beat, in order.
// Configuration goes through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Index 0 selects the separator set,
// index 1 the word limit. Write it only while no line bytes are in flight.
// A byte is registered in the front end's queue and its result in the back
// end's output queue, from whose head the result port is driven.
// Throughput is one byte per cycle while push stays high and the receiver
// keeps popping; the back end state machine updates once per byte, and the
// two-beat queues on both sides of it buffer a stall on either side.
// When the receiver stops popping, the output queue fills, then the inner
// queue, and then full rises; nothing is lost. Reset clears both queues,
// the parser state and the registers (comma off, limit 32).
module quote_aware_word_splitter_top
    import qws_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  item_t            item,
    output logic             empty,
    input  logic             pop,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [CNT_W-1:0] cfg_data
);

    logic             separator_set_reg;
    logic [CNT_W-1:0] max_words_reg;
    cfg_t             cfg;
    logic             cls_valid;
    logic             cls_take;
    cls_t             cls;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_set_reg <= 1'b0;
            max_words_reg     <= WORD_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SEPARATOR_SET:
                begin
                    separator_set_reg <= cfg_data[0];
                end
                CFG_MAX_WORDS:
                begin
                    max_words_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // The effective limit clamps a zero limit to one and caps it at WORD_LIMIT.
    always_comb
    begin
        cfg.separator_set = separator_set_reg;
        if (max_words_reg == '0)
        begin
            cfg.word_limit = {{(CNT_W-1){1'b0}}, 1'b1};
        end
        else if (max_words_reg > WORD_LIMIT)
        begin
            cfg.word_limit = WORD_LIMIT;
        end
        else
        begin
            cfg.word_limit = max_words_reg;
        end
    end

    qws_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .push      (push),
        .full      (full),
        .item      (item),
        .cls_valid (cls_valid),
        .cls_take  (cls_take),
        .cls       (cls)
    );

    qws_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cls_valid (cls_valid),
        .cls_take  (cls_take),
        .cls       (cls),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the quote-aware word splitter.
// Drives text bytes and configuration writes, predicts each result beat and
// compares it field by field. Depends on qws_pkg and quote_aware_word_splitter_top.
module tb_top
    import qws_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any accepted beat before the run is declared hung.
    localparam int STALL_LIMIT     = 1000;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int NUM_PHASES      = 7;
    localparam int NUM_DIR         = 26;
    // Idle chance per cycle, in percent, on either side.
    localparam int IDLE_PCT        = 12;

    // Kinds of directed table rows: a text byte beat or a register write.
    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_SET_SEP,
        ROW_SET_MAX
    } row_kind_t;

    // One row of the directed table. For register rows, val carries the data.
    // When typed is set, want is the result to check instead of the prediction.
    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] val;
        logic       last;
        logic       typed;
        result_t    want;
    } stim_row_t;

    localparam result_t NO_WANT = '0;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    item_t            item = '0;
    logic             empty;
    logic             pop = 1'b0;
    result_t          result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_index = 1'b0;
    logic [CNT_W-1:0] cfg_data = '0;

    quote_aware_word_splitter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Our own copy of the splitter's registers and line state. It starts at
    // the reset values and follows every accepted write and byte beat.
    logic             sp_sep_set = 1'b0;
    logic [CNT_W-1:0] sp_max     = WORD_LIMIT;
    phase_t           sp_phase   = PH_LEAD;
    quote_t           sp_quote   = Q_NONE;
    logic             sp_escape  = 1'b0;
    logic [CNT_W-1:0] sp_words   = '0;
    logic             sp_stopped = 1'b0;

    // Results still owed by the block, oldest first.
    result_t          awaited_results[$];
    int               mismatches = 0;
    int               stall_cycles = 0;
    bit               tx_idle_on = 1'b1;
    bit               rx_idle_on = 1'b1;
    logic [7:0]       line_buf[$];
    result_t          head;

    // Directed rows. Each row below is one byte beat or one register write.
    stim_row_t dir_rows [NUM_DIR] = '{
        // A line of only a separator still counts one empty word.
        '{ROW_BYTE, CH_SPACE, 1'b1, 1'b1, '{1'b0, CH_SPACE, 5'd0, 1'b1, 1'b1, 6'd1, 1'b0}},
        // Two quotes in a row give an empty word that ends at once.
        '{ROW_BYTE, CH_SQUOTE, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, CH_SQUOTE, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, CH_SPACE,  1'b1, 1'b0, NO_WANT},
        // Inside a double-quoted word a space and a single quote are text;
        // the equals sign after the closing quote separates the next word.
        '{ROW_BYTE, CH_DQUOTE, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h61,     1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, CH_SPACE,  1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, CH_SQUOTE, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, CH_DQUOTE, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, CH_EQUALS, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h63,     1'b1, 1'b0, NO_WANT},
        // Escaped separator, then a backslash as the final byte of the line.
        '{ROW_BYTE, CH_BSLASH, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, CH_EQUALS, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, CH_BSLASH, 1'b1, 1'b0, NO_WANT},
        // Byte extremes: a zero byte is plain text, and so is 0xFF.
        '{ROW_BYTE, 8'h00, 1'b0, 1'b1, '{1'b1, 8'h00, 5'd0, 1'b0, 1'b0, 6'd0, 1'b0}},
        '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, '{1'b1, 8'hFF, 5'd0, 1'b1, 1'b1, 6'd1, 1'b0}},
        // A quote closing the line after a separator opens nothing.
        '{ROW_BYTE, 8'h61,     1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, CH_SPACE,  1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, CH_SQUOTE, 1'b1, 1'b0, NO_WANT},
        // A lone quote as the whole line opens the empty first word.
        '{ROW_BYTE, CH_SQUOTE, 1'b1, 1'b1, '{1'b0, CH_SQUOTE, 5'd0, 1'b1, 1'b1, 6'd1, 1'b0}},
        // Comma separators and a limit of one word.
        '{ROW_SET_SEP, 8'd1, 1'b0, 1'b0, NO_WANT},
        '{ROW_SET_MAX, 8'd1, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h61,    1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, CH_COMMA, 1'b0, 1'b0, NO_WANT},
        // The second word hits the limit; the rest of the line is dropped.
        '{ROW_BYTE, 8'h62,     1'b0, 1'b1, '{1'b0, 8'h62, 5'd0, 1'b0, 1'b0, 6'd0, 1'b1}},
        '{ROW_BYTE, CH_EQUALS, 1'b1, 1'b1, '{1'b0, CH_EQUALS, 5'd0, 1'b0, 1'b1, 6'd1, 1'b1}}
    };

    // Register settings of the random phases, extremes among them. The first
    // phase runs without idling on either side.
    logic             phase_sep [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic [CNT_W-1:0] phase_max [NUM_PHASES] = '{6'd32, 6'd2, 6'd0, 6'd63, 6'd5, 6'd1, 6'd17};

    function automatic logic is_separator(input logic [7:0] b);
        if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF)
            return 1'b1;
        return sp_sep_set ? (b == CH_COMMA) : (b == CH_EQUALS);
    endfunction

    function automatic quote_t quote_of(input logic [7:0] b);
        if (b == CH_SQUOTE)
            return Q_SINGLE;
        if (b == CH_DQUOTE)
            return Q_DOUBLE;
        return Q_NONE;
    endfunction

    // The word limit in force: zero behaves as one, and anything above the
    // hardware limit is clipped to it.
    function automatic logic [CNT_W-1:0] eff_limit();
        if (sp_max == '0)
            return CNT_W'(1);
        if (sp_max > WORD_LIMIT)
            return WORD_LIMIT;
        return sp_max;
    endfunction

    // Advances the line state by one byte and returns the result it yields.
    function automatic result_t split_byte(input item_t it);
        logic [7:0] b;
        logic       fin;
        logic       wb;
        logic       closed;
        logic       in_word;
        result_t    r;
        b       = it.byte_value;
        fin     = it.last_byte;
        wb      = 1'b0;
        closed  = 1'b0;
        in_word = 1'b0;

        // Once the limit is hit the rest of the line is dropped, and an
        // escaped byte is taken as text without further look.
        if (sp_stopped)
        begin
        end
        else if (sp_escape)
        begin
            sp_escape = 1'b0;
            wb        = 1'b1;
        end
        else if (sp_phase == PH_LEAD || sp_phase == PH_BETWEEN)
        begin
            if (!is_separator(b))
            begin
                if (quote_of(b) != Q_NONE)
                begin
                    sp_quote = quote_of(b);
                    sp_phase = PH_QPEND;
                end
                else
                    in_word = 1'b1;
            end
        end
        else
            in_word = 1'b1;

        // Opening a new word, unless that word would exceed the limit.
        if (in_word && sp_phase != PH_WORD)
        begin
            if (sp_words != '0 && sp_words >= eff_limit())
            begin
                sp_stopped = 1'b1;
                in_word    = 1'b0;
            end
            else
            begin
                sp_words = sp_words + CNT_W'(1);
                sp_phase = PH_WORD;
            end
        end

        if (in_word)
        begin
            if (b == CH_BSLASH && !fin)
            begin
                sp_escape = 1'b1;
                wb        = 1'b1;
            end
            else if (sp_quote != Q_NONE && quote_of(b) == sp_quote)
            begin
                sp_quote = Q_NONE;
                sp_phase = PH_BETWEEN;
                closed   = 1'b1;
            end
            else if (sp_quote == Q_NONE && is_separator(b))
            begin
                sp_phase = PH_BETWEEN;
                closed   = 1'b1;
            end
            else
                wb = 1'b1;
        end

        // End of line closes an open word, or the empty first word if no
        // word was opened at all.
        if (fin && !sp_stopped)
        begin
            if (sp_phase == PH_WORD)
                closed = 1'b1;
            else if (sp_words == '0 && (sp_phase == PH_LEAD || sp_phase == PH_QPEND))
            begin
                sp_words = CNT_W'(1);
                closed   = 1'b1;
            end
        end

        r.word_byte   = wb;
        r.byte_out    = b;
        r.word_index  = (sp_words == '0) ? 5'd0 : 5'(sp_words - CNT_W'(1));
        r.word_closed = closed;
        r.done_res    = fin;
        r.word_count  = fin ? sp_words : '0;
        r.limit_hit   = sp_stopped;

        if (fin)
        begin
            sp_phase   = PH_LEAD;
            sp_quote   = Q_NONE;
            sp_escape  = 1'b0;
            sp_words   = '0;
            sp_stopped = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [7:0] pick_sep();
        case ($urandom_range(5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            3:       return CH_LF;
            4:       return CH_EQUALS;
            default: return CH_COMMA;
        endcase
    endfunction

    // Mostly lowercase letters, now and then any byte value at all.
    function automatic logic [7:0] pick_text();
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255));
        return 8'h61 + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] pick_special();
        case ($urandom_range(4))
            0:       return CH_SQUOTE;
            1:       return CH_DQUOTE;
            2:       return CH_BSLASH;
            3:       return pick_sep();
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Builds one text line into line_buf. Most lines are well formed: words
    // between separator runs, some quoted, some with escapes, and now and then
    // more words than the limit allows. The rest are noise or cut short.
    function automatic void gen_line();
        int         n_words;
        int         n_bytes;
        int         lim;
        logic [7:0] q;
        line_buf.delete();
        lim = int'(eff_limit());

        if ($urandom_range(9) == 0)
        begin
            n_bytes = 1 + $urandom_range(11);
            repeat (n_bytes)
                line_buf.push_back($urandom_range(1) ? 8'($urandom_range(255)) : pick_special());
            return;
        end

        if ($urandom_range(19) == 0)
            n_words = lim + 1 + $urandom_range(1);
        else
            n_words = 1 + $urandom_range(lim < 5 ? lim : 5);

        if ($urandom_range(1))
            repeat (1 + $urandom_range(1))
                line_buf.push_back(pick_sep());

        for (int w = 0; w < n_words; w++)
        begin
            if (w > 0)
                repeat (1 + $urandom_range(1))
                    line_buf.push_back(pick_sep());
            if ($urandom_range(3) == 0)
            begin
                // Quoted word: separators and the other quote are text inside.
                q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
                line_buf.push_back(q);
                repeat ($urandom_range(5))
                begin
                    case ($urandom_range(9))
                        0:
                        begin
                            line_buf.push_back(CH_BSLASH);
                            line_buf.push_back(8'($urandom_range(255)));
                        end
                        1:       line_buf.push_back(pick_sep());
                        2:       line_buf.push_back(q == CH_SQUOTE ? CH_DQUOTE : CH_SQUOTE);
                        default: line_buf.push_back(pick_text());
                    endcase
                end
                if ($urandom_range(9) != 0)
                    line_buf.push_back(q);
            end
            else
            begin
                repeat (1 + $urandom_range(4))
                begin
                    if ($urandom_range(99) < 15)
                    begin
                        line_buf.push_back(CH_BSLASH);
                        line_buf.push_back(8'($urandom_range(255)));
                    end
                    else
                        line_buf.push_back(pick_text());
                end
            end
        end

        if ($urandom_range(9) < 3)
            line_buf.push_back(pick_sep());
        // A few lines end on a dangling backslash or quote.
        if ($urandom_range(19) == 0)
            line_buf.push_back($urandom_range(1) ? CH_BSLASH : CH_SQUOTE);
    endfunction

    // Offers one byte beat; entered and left at a falling edge. The
    // prediction is made when the beat is taken, so it always follows the
    // order in which the block sees the bytes.
    task automatic send_item(input item_t it, input logic typed, input result_t want);
        result_t r;
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        r = split_byte(it);
        awaited_results.push_back(typed ? want : r);
        @(negedge clk);
    endtask

    // Holds the sender off until every owed result has come back.
    task automatic drain();
        push <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
    endtask

    // One register write beat. Valid is lowered again before the task returns, so a
    // following write never lowers and raises it in the same time step.
    task automatic write_reg(input logic idx, input logic [CNT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_SEPARATOR_SET)
            sp_sep_set = val[0];
        else
            sp_max = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // The receiver pops at random, holding back in about one cycle of eight.
    always @(negedge clk)
        pop <= rst_n && !(rx_idle_on && $urandom_range(99) < IDLE_PCT);

    // Every result beat is matched against the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result beat with no byte outstanding: %h", result);
                mismatches++;
            end
            else
            begin
                head = awaited_results.pop_front();
                check_field("word_byte",   32'(head.word_byte),   32'(result.word_byte));
                check_field("byte_out",    32'(head.byte_out),    32'(result.byte_out));
                check_field("word_index",  32'(head.word_index),  32'(result.word_index));
                check_field("word_closed", 32'(head.word_closed), 32'(result.word_closed));
                check_field("done_res",    32'(head.done_res),    32'(result.done_res));
                check_field("word_count",  32'(head.word_count),  32'(result.word_count));
                check_field("limit_hit",   32'(head.limit_hit),   32'(result.limit_hit));
            end
        end
    end

    // Watchdog: any accepted beat on any channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        item_t it;
        int    n_sent;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, run at the reset settings until its own writes.
        foreach (dir_rows[i])
        begin
            case (dir_rows[i].kind)
                ROW_BYTE:
                begin
                    it.byte_value = dir_rows[i].val;
                    it.last_byte  = dir_rows[i].last;
                    send_item(it, dir_rows[i].typed, dir_rows[i].want);
                end
                ROW_SET_SEP:
                begin
                    drain();
                    write_reg(CFG_SEPARATOR_SET, CNT_W'(dir_rows[i].val));
                end
                default:
                begin
                    drain();
                    write_reg(CFG_MAX_WORDS, CNT_W'(dir_rows[i].val));
                end
            endcase
        end
        drain();

        // Random lines, one register setting per phase. Each phase ends on a
        // line boundary and waits for every result before the next writes.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            tx_idle_on = (p != 0);
            rx_idle_on = (p != 0);
            write_reg(CFG_SEPARATOR_SET, CNT_W'(phase_sep[p]));
            write_reg(CFG_MAX_WORDS, phase_max[p]);
            n_sent = 0;
            while (n_sent < ITEMS_PER_PHASE)
            begin
                gen_line();
                foreach (line_buf[k])
                begin
                    it.byte_value = line_buf[k];
                    it.last_byte  = (k == line_buf.size() - 1);
                    send_item(it, 1'b0, NO_WANT);
                end
                n_sent += line_buf.size();
            end
            drain();
        end

        // Let a stray extra result show up before the verdict.
        repeat (8) @(posedge clk);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
